/* rtl/core/csvc_pkg.sv */
// Shared types and constants for the CompactSize varint codec.
// Used by the front end, the work queue, the back end and the top level.
package csvc_pkg;

   // Values of the result's kind field.
   localparam logic KIND_VALUE = 1'b0;
   localparam logic KIND_BYTE  = 1'b1;

   // Prefix bytes that announce a 2-, 4- or 8-byte payload.
   localparam logic [7:0] PREFIX_16 = 8'hFD;
   localparam logic [7:0] PREFIX_32 = 8'hFE;
   localparam logic [7:0] PREFIX_64 = 8'hFF;

   // Payload byte counts announced by the prefixes.
   localparam logic [3:0] PAYLOAD_16 = 4'd2;
   localparam logic [3:0] PAYLOAD_32 = 4'd4;
   localparam logic [3:0] PAYLOAD_64 = 4'd8;

   // Length class of an encoding: total bytes on the wire.
   typedef enum logic [1:0] {
      LEN_1 = 2'd0,
      LEN_3 = 2'd1,
      LEN_5 = 2'd2,
      LEN_9 = 2'd3
   } csvc_len_type;

   // One unit of work handed from the front end to the back end.
   typedef struct packed {
      logic         kind;
      csvc_len_type len;
      logic [63:0]  value;
   } csvc_desc_type;

endpackage

/* rtl/core/csvc_front.sv */
// Front end of the CompactSize codec: holds the direction register, runs the
// byte gatherer for decoding and classifies values for encoding. Uses csvc_pkg.
module csvc_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write,
   input  logic                   csr_wdata,
   input  logic                   accept,
   input  logic [7:0]             in_byte,
   input  logic [63:0]            in_value,
   output logic                   push,
   output csvc_pkg::csvc_desc_type push_desc
);
   import csvc_pkg::*;

   logic        direction_ff, direction_in;
   logic [3:0]  remaining_ff, remaining_in;
   logic [2:0]  index_ff, index_in;
   logic [63:0] gathered_ff, gathered_in;
   logic [63:0] merged;
   csvc_len_type enc_len;

   // The incoming byte dropped into its lane of the partial value.
   always_comb begin
      merged = gathered_ff;
      for (int i = 0; i < 8; i++) begin
         if (index_ff == 3'(i)) begin
            merged[8*i +: 8] = in_byte;
         end
      end
   end

   always_comb begin
      if (in_value[63:32] != 32'd0) begin
         enc_len = LEN_9;
      end else if (in_value[31:16] != 16'd0) begin
         enc_len = LEN_5;
      end else if (in_value[15:0] >= {8'd0, PREFIX_16}) begin
         enc_len = LEN_3;
      end else begin
         enc_len = LEN_1;
      end
   end

   always_comb begin
      direction_in    = direction_ff;
      remaining_in    = remaining_ff;
      index_in        = index_ff;
      gathered_in     = gathered_ff;
      push            = 1'b0;
      push_desc.kind  = KIND_VALUE;
      push_desc.len   = LEN_1;
      push_desc.value = {56'd0, in_byte};
      if (csr_write) begin
         direction_in = csr_wdata;
         remaining_in = 4'd0;
         index_in     = 3'd0;
      end else if (accept) begin
         if (direction_ff) begin
            push            = 1'b1;
            push_desc.kind  = KIND_BYTE;
            push_desc.len   = enc_len;
            push_desc.value = in_value;
         end else if (remaining_ff == 4'd0) begin
            if (in_byte < PREFIX_16) begin
               push = 1'b1;
            end else begin
               index_in    = 3'd0;
               gathered_in = 64'd0;
               priority case (in_byte)
                  PREFIX_16: remaining_in = PAYLOAD_16;
                  PREFIX_32: remaining_in = PAYLOAD_32;
                  default:   remaining_in = PAYLOAD_64;
               endcase
            end
         end else begin
            remaining_in    = remaining_ff - 4'd1;
            index_in        = index_ff + 3'd1;
            gathered_in     = merged;
            push_desc.value = merged;
            if (remaining_ff == 4'd1) begin
               push     = 1'b1;
               index_in = 3'd0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         direction_ff <= 1'b0;
         remaining_ff <= 4'd0;
         index_ff     <= 3'd0;
      end else begin
         direction_ff <= direction_in;
         remaining_ff <= remaining_in;
         index_ff     <= index_in;
      end
      gathered_ff <= gathered_in;
   end

endmodule

/* rtl/core/csvc_queue.sv */
// Small register queue that decouples the codec's front and back ends.
// Holds csvc_pkg descriptors; DEPTH sets the number of entries.
module csvc_queue #(
   parameter int DEPTH = 2
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  csvc_pkg::csvc_desc_type push_desc,
   input  logic                    pop,
   output logic                    full,
   output logic                    head_valid,
   output csvc_pkg::csvc_desc_type head_desc
);
   import csvc_pkg::*;

   localparam int PtrWidth   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CountWidth = $clog2(DEPTH + 1);

   csvc_desc_type         entries_ff [DEPTH];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic                  do_push, do_pop;

   assign full       = (count_ff == CountWidth'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_desc  = entries_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_desc;
      end
   end

endmodule

/* rtl/core/csvc_back.sv */
// CompactSize codec back end: queued descriptors become result words, one
// per cycle unless stalled, via a registered output stage. Uses csvc_pkg.
module csvc_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    head_valid,
   input  csvc_pkg::csvc_desc_type head_desc,
   output logic                    pop,
   input  logic                    rsp_stall,
   output logic                    rsp_valid,
   output logic                    rsp_out_kind,
   output logic [63:0]             rsp_out_value,
   output logic [7:0]              rsp_out_byte,
   output logic                    rsp_last
);
   import csvc_pkg::*;

   logic [3:0]  pos_ff, pos_in;
   logic        valid_ff, valid_in;
   logic        kind_ff;
   logic [63:0] value_ff, value_in;
   logic [7:0]  byte_ff, byte_in;
   logic        last_ff, last_in;
   logic [3:0]  last_pos;
   logic [7:0]  prefix;
   logic [2:0]  lane;
   logic [7:0]  lane_byte;
   logic        load;

   assign load = head_valid && (!valid_ff || !rsp_stall);
   assign lane = pos_ff[2:0] - 3'd1;

   always_comb begin
      lane_byte = 8'd0;
      for (int i = 0; i < 8; i++) begin
         if (lane == 3'(i)) begin
            lane_byte = head_desc.value[8*i +: 8];
         end
      end
   end

   always_comb begin
      unique case (head_desc.len)
         LEN_1: begin
            last_pos = 4'd0;
            prefix   = head_desc.value[7:0];
         end
         LEN_3: begin
            last_pos = PAYLOAD_16;
            prefix   = PREFIX_16;
         end
         LEN_5: begin
            last_pos = PAYLOAD_32;
            prefix   = PREFIX_32;
         end
         LEN_9: begin
            last_pos = PAYLOAD_64;
            prefix   = PREFIX_64;
         end
         default: begin
            last_pos = 4'd0;
            prefix   = 8'd0;
         end
      endcase
   end

   always_comb begin
      if (head_desc.kind == KIND_VALUE) begin
         value_in = head_desc.value;
         byte_in  = 8'd0;
         last_in  = 1'b1;
      end else begin
         value_in = 64'd0;
         byte_in  = (pos_ff == 4'd0) ? prefix : lane_byte;
         last_in  = (pos_ff == last_pos);
      end
      pop      = load && last_in;
      pos_in   = pos_ff;
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
         pos_in   = last_in ? 4'd0 : pos_ff + 4'd1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         pos_ff   <= 4'd0;
      end else begin
         valid_ff <= valid_in;
         pos_ff   <= pos_in;
      end
      if (load) begin
         kind_ff  <= head_desc.kind;
         value_ff <= value_in;
         byte_ff  <= byte_in;
         last_ff  <= last_in;
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_out_kind  = kind_ff;
   assign rsp_out_value = value_ff;
   assign rsp_out_byte  = byte_ff;
   assign rsp_last      = last_ff;

endmodule

/* rtl/core/compact_size_varint_codec_unit.sv */
// Top level of the CompactSize varint codec: front end, work queue, back end.
// Depends on csvc_pkg, csvc_front, csvc_queue and csvc_back.

// The codec decodes (direction 0) or encodes (direction 1) CompactSize
// integers. Decoding takes one byte per cycle with no gaps while the work
// queue is not full; a value word follows the byte that completes it.
// Encoding takes one 64-bit value and emits 1, 3, 5 or 9 byte words, one
// per cycle from the output register unless rsp_stall holds it; the input
// side keeps accepting until the QUEUE_DEPTH-entry work queue between the
// front and back ends is full. A result passes through the work queue and
// the output register. Write the direction only while the codec is idle; a
// write also abandons any partly gathered decode.
module compact_size_varint_codec_unit #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_wdata,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   input  logic [63:0] req_in_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_out_kind,
   output logic [63:0] rsp_out_value,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_last
);
   import csvc_pkg::*;

   logic          accept;
   logic          push;
   csvc_desc_type push_desc;
   logic          pop;
   logic          full;
   logic          head_valid;
   csvc_desc_type head_desc;

   assign csr_ready = 1'b1;
   assign req_stall = full;
   assign accept    = req_valid && !full;

   csvc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_valid && csr_ready),
      .csr_wdata (csr_wdata),
      .accept    (accept),
      .in_byte   (req_in_byte),
      .in_value  (req_in_value),
      .push      (push),
      .push_desc (push_desc)
   );

   csvc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_desc  (push_desc),
      .pop        (pop),
      .full       (full),
      .head_valid (head_valid),
      .head_desc  (head_desc)
   );

   csvc_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head_valid    (head_valid),
      .head_desc     (head_desc),
      .pop           (pop),
      .rsp_stall     (rsp_stall),
      .rsp_valid     (rsp_valid),
      .rsp_out_kind  (rsp_out_kind),
      .rsp_out_value (rsp_out_value),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_last      (rsp_last)
   );

`ifndef NO_ASSERTIONS
   // An encoding that has started keeps streaming: the next byte is ready
   // right after a byte that is not the last one is taken.
   a_encode_continues: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_out_kind == KIND_BYTE && !rsp_last)
      |=> (rsp_valid && rsp_out_kind == KIND_BYTE))
      else $error("encoding broke off before its last byte");

   // Decoded values always close their result and carry no byte.
   a_value_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_out_kind == KIND_VALUE) |-> (rsp_last && rsp_out_byte == 8'd0))
      else $error("decoded value word malformed");

   // Queued work reaches an empty output register in the next cycle.
   a_back_drains: assert property (@(posedge clock) disable iff (reset)
      (head_valid && !rsp_valid) |=> rsp_valid)
      else $error("back end left queued work waiting");
`endif

endmodule
